// File: hdl/pfa_pkg.sv
package pfa_pkg;

  // Store geometry. WORD_BITS is a power of two.
  localparam int NUM_PAGES = 65536;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int DELTA_W   = BIT_W + 1;

  // Field widths.
  localparam int CMD_W = 3;
  localparam int IDX_W = 16;
  localparam int CNT_W = 17;
  localparam int END_W = ($clog2(NUM_PAGES + 1) > IDX_W + 2) ? $clog2(NUM_PAGES + 1) : IDX_W + 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOCK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;

  // Pages of the last word that lie inside the store.
  localparam word_t LAST_MASK = ((NUM_PAGES % WORD_BITS) == 0) ? '1 :
                                ((word_t'(1) << (NUM_PAGES % WORD_BITS)) - word_t'(1));

  // Position of the current word within the run or the scan.
  typedef struct packed {
    logic             lo_edge;
    logic             hi_edge;
    logic [BIT_W-1:0] lo_bit;
    logic [BIT_W-1:0] hi_bit;
    logic             last_word;
  } wop_ctl_t;

  // Updated word and what changed in it.
  typedef struct packed {
    word_t              new_word;
    logic [DELTA_W-1:0] delta;
    logic               hit;
    logic [BIT_W-1:0]   hit_bit;
  } wop_res_t;

endpackage

// File: hdl/pfa_ram.sv
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/pfa_word_op.sv
module pfa_word_op (
  input  logic [pfa_pkg::CMD_W-1:0] cmd,
  input  pfa_pkg::word_t            word,
  input  pfa_pkg::wop_ctl_t         ctl,
  output pfa_pkg::wop_res_t         res
);
  import pfa_pkg::*;

  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);

  word_t              all_ones;
  word_t              run_mask;
  word_t              change;
  word_t              avail;
  logic               set_op;
  logic               hit;
  logic [BIT_W-1:0]   low_bit;
  logic [DELTA_W-1:0] sums [WORD_BITS];

  // Pages of the run that fall into this word.
  always_comb begin
    all_ones = '1;
    run_mask = (ctl.lo_edge ? (all_ones << ctl.lo_bit) : all_ones) &
               (ctl.hi_edge ? (all_ones >> (TOP_BIT - ctl.hi_bit)) : all_ones);
    set_op   = (cmd == CMD_LOCK) || (cmd == CMD_RESERVE);
    change   = set_op ? (run_mask & ~word) : (run_mask & word);
  end

  // Count of bits that flip, as an adder tree.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      sums[i] = DELTA_W'(change[i]);
    end
    for (int lvl = 0; lvl < BIT_W; lvl++) begin
      for (int i = 0; i < (WORD_BITS >> (lvl + 1)); i++) begin
        sums[i] = sums[2*i] + sums[2*i+1];
      end
    end
  end

  // Lowest free page of the word for allocate.
  always_comb begin
    avail   = ~word & (ctl.last_word ? LAST_MASK : all_ones);
    hit     = |avail;
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        low_bit = BIT_W'(i);
      end
    end
  end

  always_comb begin
    res.hit     = hit;
    res.hit_bit = low_bit;
    if (cmd == CMD_ALLOC) begin
      res.new_word = hit ? (word | (word_t'(1) << low_bit)) : word;
      res.delta    = DELTA_W'(hit);
    end else begin
      res.new_word = set_op ? (word | change) : (word & ~change);
      res.delta    = sums[0];
    end
  end

endmodule

// File: hdl/bitmap_page_frame_allocator.sv
// Single-page command: the word is read (ST_RD), modified and written back (ST_MOD), then the
// counters update (ST_UPD) and the result is registered; the next input is taken after that,
// waiting while the output stalls. Runs repeat ST_MOD and ST_UPD per bitmap word touched and
// allocate per word scanned, up to 1024; both are set by the bitmap read-modify-write loop.
// Unknown commands and empty runs skip the RAM. Reset is synchronous; a clearing pass then
// writes all 1024 bitmap words with s_tready low. Configuration writes are taken at any time.
module bitmap_page_frame_allocator (
  input  logic                            clk,
  input  logic                            rst,
  // Command stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pfa_pkg::IN_DATA_W-1:0]   s_tdata,  // page_index[15:0], run_length[32:16]
  input  logic [pfa_pkg::CMD_W-1:0]       s_tuser,  // cmd[2:0]
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pfa_pkg::OUT_DATA_W-1:0]  m_tdata,  // alloc_page[15:0], free_pages[32:16],
                                                    // used_pages[49:33], reserved_pages[66:50]
  output logic [0:0]                      m_tuser,  // alloc_found[0]
  // Free page counter load.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfa_pkg::CNT_W-1:0]       cfg_data
);
  import pfa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_RESP = 3'd5;

  logic [2:0]         state;
  logic [WADDR_W-1:0] w;
  logic [CMD_W-1:0]   cmd_r;
  logic [IDX_W-1:0]   first_r;
  logic [END_W-1:0]   end_r;
  logic [DELTA_W-1:0] delta_r;
  logic               done_r;
  logic               found_r;
  logic [IDX_W-1:0]   apage_r;

  logic [CNT_W-1:0] free_count, used_count, reserved_count;
  logic [CNT_W-1:0] free_next, used_next, reserved_next;

  logic [IDX_W-1:0] out_page;
  logic [CNT_W-1:0] out_free, out_used, out_reserved;
  logic             out_found;

  logic [IDX_W-1:0] in_index;
  logic [CNT_W-1:0] in_count;
  logic [END_W-1:0] in_sum;
  logic [END_W-1:0] in_end;
  logic             in_empty;
  logic [31:0]      in_word_tmp;

  logic [END_W-1:0] end_m1;
  logic [31:0]      last_tmp, first_tmp, page_tmp;
  logic [WADDR_W-1:0] first_w, last_w;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_raddr;
  word_t              ram_wdata, ram_rdata;
  wop_ctl_t           wctl;
  wop_res_t           wres;
  logic               accept, out_load;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [DELTA_W-1:0] d);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W + 1)'(d);
    sat_add = s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] c,
                                                input logic [DELTA_W-1:0] d);
    sat_sub = (c >= CNT_W'(d)) ? (c - CNT_W'(d)) : '0;
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // Clip the run to the store at the input transfer.
  always_comb begin
    in_index    = s_tdata[IDX_W-1:0];
    in_count    = s_tdata[IDX_W+CNT_W-1:IDX_W];
    in_sum      = END_W'(in_index) + END_W'(in_count);
    in_end      = (in_sum > END_W'(NUM_PAGES)) ? END_W'(NUM_PAGES) : in_sum;
    in_empty    = (in_count == '0) || (32'(in_index) >= 32'(NUM_PAGES));
    in_word_tmp = 32'(in_index) >> BIT_W;
  end

  // Position of the current word within the run.
  always_comb begin
    end_m1         = end_r - END_W'(1);
    last_tmp       = 32'(end_m1) >> BIT_W;
    first_tmp      = 32'(first_r) >> BIT_W;
    last_w         = last_tmp[WADDR_W-1:0];
    first_w        = first_tmp[WADDR_W-1:0];
    wctl.lo_edge   = (w == first_w);
    wctl.hi_edge   = (w == last_w);
    wctl.lo_bit    = first_r[BIT_W-1:0];
    wctl.hi_bit    = end_m1[BIT_W-1:0];
    wctl.last_word = (w == WADDR_W'(NUM_WORDS - 1));
    page_tmp       = (32'(w) << BIT_W) | 32'(wres.hit_bit);
  end

  // Bitmap RAM access: clear sweep, write-back of the modified word, read ahead.
  always_comb begin
    ram_we    = (state == ST_CLR) || (state == ST_MOD);
    ram_wdata = (state == ST_CLR) ? '0 : wres.new_word;
    ram_raddr = (state == ST_UPD) ? WADDR_W'(w + 1'b1) : w;
  end

  pfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfa_word_op u_word_op (
    .cmd  (cmd_r),
    .word (ram_rdata),
    .ctl  (wctl),
    .res  (wres)
  );

  // Counter update from the registered change count.
  always_comb begin
    free_next     = free_count;
    used_next     = used_count;
    reserved_next = reserved_count;
    if (state == ST_UPD) begin
      unique case (cmd_r)
        CMD_LOCK, CMD_ALLOC: begin
          free_next = sat_sub(free_count, delta_r);
          used_next = sat_add(used_count, delta_r);
        end
        CMD_FREE: begin
          free_next = sat_add(free_count, delta_r);
          used_next = sat_sub(used_count, delta_r);
        end
        CMD_RESERVE: begin
          free_next     = sat_sub(free_count, delta_r);
          reserved_next = sat_add(reserved_count, delta_r);
        end
        CMD_UNRESERVE: begin
          free_next     = sat_add(free_count, delta_r);
          reserved_next = sat_sub(reserved_count, delta_r);
        end
        default: begin
          free_next = free_count;
        end
      endcase
    end
  end

  assign out_load = ((state == ST_UPD && done_r) || state == ST_RESP) &&
                    (!m_tvalid || m_tready);

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLR;
      w              <= '0;
      free_count     <= TOTAL_RESET;
      used_count     <= '0;
      reserved_count <= '0;
    end else begin
      used_count     <= used_next;
      reserved_count <= reserved_next;
      if (cfg_valid) begin
        free_count <= cfg_data;
      end else begin
        free_count <= free_next;
      end
      unique case (state)
        ST_CLR: begin
          if (w == WADDR_W'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
          w <= WADDR_W'(w + 1'b1);
        end
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == CMD_ALLOC) begin
              w     <= '0;
              state <= ST_RD;
            end else if (s_tuser <= CMD_UNRESERVE && !in_empty) begin
              w     <= in_word_tmp[WADDR_W-1:0];
              state <= ST_RD;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        ST_RD: begin
          state <= ST_MOD;
        end
        ST_MOD: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (done_r) begin
            state <= out_load ? ST_IDLE : ST_RESP;
          end else begin
            w     <= WADDR_W'(w + 1'b1);
            state <= ST_MOD;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command payload and per-word results.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= s_tuser;
      first_r <= in_index;
      end_r   <= in_end;
      found_r <= 1'b0;
      apage_r <= '0;
    end
    if (state == ST_MOD) begin
      delta_r <= wres.delta;
      if (cmd_r == CMD_ALLOC) begin
        done_r <= wres.hit || wctl.last_word;
        if (wres.hit) begin
          found_r <= 1'b1;
          apage_r <= page_tmp[IDX_W-1:0];
        end
      end else begin
        done_r <= wctl.hi_edge;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found    <= found_r;
      out_page     <= apage_r;
      out_free     <= free_next;
      out_used     <= used_next;
      out_reserved <= reserved_next;
    end
  end

  assign m_tuser = out_found;
  assign m_tdata = {(OUT_DATA_W - IDX_W - 3 * CNT_W)'(0), out_reserved, out_used, out_free,
                    out_page};

endmodule

// File: tb/sv/pfa_frame_checker.sv
`timescale 1ns / 100ps

module pfa_frame_checker
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // page_index[15:0], run_length[32:16]
  input  logic [CMD_W-1:0]      s_tuser,   // cmd[2:0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // alloc_page, free, used, reserved
  input  logic [0:0]            m_tuser,   // alloc_found[0]
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  output int                    pending,
  output int                    fail_count
);

  // Allocation outcome and counter snapshot that follow one command.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] page;
    logic [CNT_W-1:0] free_p;
    logic [CNT_W-1:0] used_p;
    logic [CNT_W-1:0] rsv_p;
  } frame_status_t;

  // Shadow copy of the busy bits and the page counters.
  word_t            busy_map [NUM_WORDS];
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] used_cnt;
  logic [CNT_W-1:0] rsv_cnt;
  frame_status_t    status_q [$];
  int               errs = 0;

  function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  // Apply one command to a single page; a bit already in the wanted state is left alone.
  function automatic void touch_page(input logic [CMD_W-1:0] op, input int unsigned pg);
    int unsigned w;
    int unsigned b;
    logic        busy;
    w    = pg / WORD_BITS;
    b    = pg % WORD_BITS;
    busy = busy_map[w][b];
    if (op == CMD_LOCK || op == CMD_RESERVE) begin
      if (!busy) begin
        busy_map[w][b] = 1'b1;
        free_cnt = cnt_down(free_cnt);
        if (op == CMD_LOCK) begin
          used_cnt = cnt_up(used_cnt);
        end else begin
          rsv_cnt = cnt_up(rsv_cnt);
        end
      end
    end else if (busy) begin
      busy_map[w][b] = 1'b0;
      free_cnt = cnt_up(free_cnt);
      if (op == CMD_FREE) begin
        used_cnt = cnt_down(used_cnt);
      end else begin
        rsv_cnt = cnt_down(rsv_cnt);
      end
    end
  endfunction

  // Work out the status that one command leaves behind.
  function automatic frame_status_t predict_status(input logic [CMD_W-1:0] op,
                                                   input logic [IDX_W-1:0] first,
                                                   input logic [CNT_W-1:0] count);
    frame_status_t st;
    int unsigned   pg;
    word_t         open_bits;
    st = '0;
    case (op)
      CMD_LOCK, CMD_FREE, CMD_RESERVE, CMD_UNRESERVE: begin
        // A run stops at the end of the store.
        for (int unsigned i = 0; i < count; i++) begin
          pg = first + i;
          if (pg >= NUM_PAGES) break;
          touch_page(op, pg);
        end
      end
      CMD_ALLOC: begin
        // First fit: lowest page whose busy bit is clear.
        for (int w = 0; w < NUM_WORDS && !st.found; w++) begin
          open_bits = ~busy_map[w];
          if (open_bits != '0) begin
            for (int b = 0; b < WORD_BITS && !st.found; b++) begin
              pg = w * WORD_BITS + b;
              if (open_bits[b] && pg < NUM_PAGES) begin
                touch_page(CMD_LOCK, pg);
                st.found = 1'b1;
                st.page  = pg[IDX_W-1:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
    st.free_p = free_cnt;
    st.used_p = used_cnt;
    st.rsv_p  = rsv_cnt;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errs < 40) $display("%0t: mismatch: %s", $time, msg);
    errs++;
  endtask

  // Track configuration, result and command transfers in that order.
  always @(posedge clk) begin
    frame_status_t got;
    frame_status_t want;
    if (rst) begin
      foreach (busy_map[w]) busy_map[w] = '0;
      free_cnt = TOTAL_RESET;
      used_cnt = '0;
      rsv_cnt  = '0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) free_cnt = cfg_data;

      if (m_tvalid && m_tready) begin
        got.found  = m_tuser[0];
        got.page   = m_tdata[15:0];
        got.free_p = m_tdata[32:16];
        got.used_p = m_tdata[49:33];
        got.rsv_p  = m_tdata[66:50];
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing outstanding: %h", got));
        end else begin
          want = status_q.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("alloc_found %0d, expected %0d", got.found, want.found));
          if (got.page !== want.page)
            report_mismatch($sformatf("alloc_page %0d, expected %0d", got.page, want.page));
          if (got.free_p !== want.free_p)
            report_mismatch($sformatf("free_pages %0d, expected %0d", got.free_p, want.free_p));
          if (got.used_p !== want.used_p)
            report_mismatch($sformatf("used_pages %0d, expected %0d", got.used_p, want.used_p));
          if (got.rsv_p !== want.rsv_p)
            report_mismatch($sformatf("reserved_pages %0d, expected %0d",
                                      got.rsv_p, want.rsv_p));
        end
      end

      if (s_tvalid && s_tready) begin
        status_q.push_back(predict_status(s_tuser, s_tdata[IDX_W-1:0],
                                          s_tdata[IDX_W +: CNT_W]));
      end
    end
    pending    <= status_q.size();
    fail_count <= errs;
  end

endmodule

// File: tb/sv/tb_bitmap_page_frame_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator;
  import pfa_pkg::*;

  localparam int CYCLE_LIMIT   = 10000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 150;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // page_index[15:0], run_length[32:16]
  logic [CMD_W-1:0]      s_tuser;   // cmd[2:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // alloc_page[15:0], free[32:16], used[49:33], rsv[66:50]
  logic [0:0]            m_tuser;   // alloc_found[0]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_data;
  int                    pending;
  int                    fail_count;
  int                    cycle_count = 0;
  logic                  no_gaps = 1'b0;

  bitmap_page_frame_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pfa_frame_checker u_frame_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly short lengths, now and then a long one.
  function automatic int short_or_long(input int short_max, input int long_min,
                                       input int long_max);
    if ($urandom_range(0, 9) == 0) return $urandom_range(long_min, long_max);
    return $urandom_range(1, short_max);
  endfunction

  // Result side backpressure: ready stretches alternate with stalls.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat (short_or_long(6, 20, 120)) @(posedge clk);
      m_tready <= 1'b0;
      repeat (short_or_long(3, 10, 60)) @(posedge clk);
    end
  end

  // One command transfer, sometimes preceded by a random gap.
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] first,
                          input logic [CNT_W-1:0] count);
    int gap;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : short_or_long(3, 10, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_DATA_W'({count, first});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command; most runs are short and land in a low window so that
  // they overlap with each other and with the pages that allocate hands out.
  task automatic send_random(input int unsigned window);
    int               roll;
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] first;
    logic [CNT_W-1:0] count;
    roll = $urandom_range(0, 99);
    if (roll < 22) op = CMD_ALLOC;
    else if (roll < 40) op = CMD_LOCK;
    else if (roll < 57) op = CMD_FREE;
    else if (roll < 73) op = CMD_RESERVE;
    else if (roll < 94) op = CMD_UNRESERVE;
    else op = CMD_ALLOC + CMD_W'($urandom_range(1, 3));

    roll = $urandom_range(0, 99);
    if (roll < 80) first = IDX_W'($urandom_range(0, window - 1));
    else if (roll < 95) first = IDX_W'($urandom);
    else first = IDX_W'($urandom_range(NUM_PAGES - 600, NUM_PAGES - 1));

    roll = $urandom_range(0, 99);
    if (roll < 5) count = '0;
    else if (roll < 75) count = CNT_W'($urandom_range(1, 8));
    else if (roll < 95) count = CNT_W'($urandom_range(9, 300));
    else count = CNT_W'($urandom_range(0, CNT_MAX));
    send_cmd(op, first, count);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_LOCK;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    cfg_write(TOTAL_RESET);

    // Directed part: store edges, full and empty store, overlaps, saturation.
    send_cmd(CMD_ALLOC, '1, CNT_MAX);
    send_cmd(CMD_LOCK, '0, '0);
    send_cmd(CMD_LOCK, '1, 17'd1);
    send_cmd(CMD_LOCK, 16'd65530, CNT_MAX);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_RESERVE, 16'd2, 17'd3);
    send_cmd(CMD_LOCK, '0, 17'd65536);
    send_cmd(CMD_ALLOC, 16'h5a5a, 17'h0a5a5);
    send_cmd(CMD_RESERVE, 16'd5, 17'd3);
    send_cmd(CMD_FREE, '0, 17'd65536);
    send_cmd(CMD_FREE, 16'd300, 17'd5);
    send_cmd(CMD_RESERVE, 16'd100, 17'd50);
    send_cmd(CMD_RESERVE, 16'd120, 17'd40);
    send_cmd(CMD_FREE, 16'd100, 17'd5);
    send_cmd(CMD_UNRESERVE, 16'd90, 17'd40);
    send_cmd(CMD_LOCK, 16'd200, 17'd4);
    send_cmd(CMD_UNRESERVE, '0, 17'd1024);
    send_cmd(CMD_UNRESERVE, '0, 17'd10);
    for (int k = 1; k <= 3; k++) begin
      send_cmd(CMD_ALLOC + CMD_W'(k), IDX_W'($urandom), CNT_W'($urandom));
    end
    send_cmd(CMD_ALLOC, '0, '0);

    // Free counter pinned at zero, then at its maximum.
    wait_idle();
    cfg_write('0);
    send_cmd(CMD_LOCK, 16'd1000, 17'd10);
    send_cmd(CMD_ALLOC, '0, '0);
    wait_idle();
    cfg_write(CNT_MAX);
    send_cmd(CMD_FREE, 16'd1000, 17'd10);
    send_cmd(CMD_UNRESERVE, '0, 17'd16);
    send_cmd(CMD_ALLOC, '0, '0);

    // Random phases, each under its own free page setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       cfg_write(CNT_W'(1));
        2:       cfg_write(TOTAL_RESET);
        default: cfg_write(CNT_W'($urandom_range(0, CNT_MAX)));
      endcase
      no_gaps = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random((phase % 2 == 0) ? 2048 : 512);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/pfa_word_op.sv
hdl/bitmap_page_frame_allocator.sv
tb/sv/pfa_frame_checker.sv
tb/sv/tb_bitmap_page_frame_allocator.sv
